[src/drpu_pkg.sv]
// Shared types, constants and the CORDIC arctangent table for the pose update block.
// No dependencies; every other file imports this package.
package drpu_pkg;

    localparam int CORDIC_STEPS_DEF = 16;
    localparam int TABLE_LEN        = 24;
    localparam int TIDX_W           = 5;

    // CORDIC datapath widths: x/y carry Q.30 values in rotation mode, z carries Q.30 angles
    localparam int CW = 56;
    localparam int ZW = 34;

    // serial multiplier operand widths
    localparam int MUL_AW = 33;
    localparam int MUL_BW = 34;

    // modulo unit widths
    localparam int MOD_AW = 24;
    localparam int MOD_DW = 15;

    localparam logic [MOD_DW-1:0] TWO_PI_TRUE  = 15'd25736;
    localparam logic [MOD_DW-1:0] TWO_PI_CONST = 15'd25723;
    localparam logic signed [16:0] TWO_PI_TRUE_S  = 17'sd25736;
    localparam logic signed [16:0] PI_TRUE_S      = 17'sd12868;
    localparam logic signed [16:0] HALF_PI_TRUE_S = 17'sd6434;
    localparam logic signed [17:0] PI_CONST_S     = 18'sd12861;
    localparam logic signed [ZW-1:0] HALF_PI_Q30  = 34'sd1686629713;
    localparam logic signed [CW-1:0] GAIN_Q30     = 56'sd652032874;

    typedef enum logic [1:0] {
        MODE_ROTATE = 2'b01,
        MODE_VECTOR = 2'b10
    } cordic_mode_t;

    typedef struct packed {
        logic signed [15:0] turn_angle;
        logic signed [23:0] move_distance;
    } in_t;

    typedef struct packed {
        logic signed [31:0] prev_x;
        logic signed [31:0] prev_y;
        logic signed [31:0] new_x;
        logic signed [31:0] new_y;
        logic        [2:0]  quadrant;
        logic        [31:0] origin_range;
        logic signed [15:0] origin_bearing;
        logic signed [15:0] realign_angle;
        logic signed [15:0] home_turn;
    } out_t;

    function automatic logic signed [ZW-1:0] atan_q30(input logic [TIDX_W-1:0] idx);
        logic signed [ZW-1:0] v;
        case (idx)
            5'd0:  v = 34'sd843314856;
            5'd1:  v = 34'sd497837829;
            5'd2:  v = 34'sd263043836;
            5'd3:  v = 34'sd133525158;
            5'd4:  v = 34'sd67021686;
            5'd5:  v = 34'sd33543515;
            5'd6:  v = 34'sd16775850;
            5'd7:  v = 34'sd8388437;
            5'd8:  v = 34'sd4194282;
            5'd9:  v = 34'sd2097149;
            5'd10: v = 34'sd1048575;
            5'd11: v = 34'sd524287;
            5'd12: v = 34'sd262143;
            5'd13: v = 34'sd131071;
            5'd14: v = 34'sd65535;
            5'd15: v = 34'sd32767;
            5'd16: v = 34'sd16383;
            5'd17: v = 34'sd8191;
            5'd18: v = 34'sd4095;
            5'd19: v = 34'sd2047;
            5'd20: v = 34'sd1023;
            5'd21: v = 34'sd511;
            5'd22: v = 34'sd255;
            5'd23: v = 34'sd127;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

[src/drpu_smod.sv]
// Serial remainder unit: truncating signed remainder by the divisor taken at start, one bit a cycle.
// Depends on drpu_pkg.
module drpu_smod
    import drpu_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic signed [MOD_AW-1:0] dividend,
    input  logic        [MOD_DW-1:0] divisor,
    output logic                     done,
    output logic signed [15:0]       remainder
);

    localparam int CNT_W = $clog2(MOD_AW);

    logic [MOD_AW-1:0] mag_reg;
    logic [MOD_DW-1:0] rem_reg;
    logic [MOD_DW-1:0] div_reg;
    logic              neg_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg;
    logic              done_reg;

    logic [MOD_DW:0]   shifted;
    logic              fits;
    logic [MOD_DW-1:0] rem_next;
    logic signed [15:0] rem_s;

    always_comb
    begin
        shifted  = {rem_reg, mag_reg[MOD_AW-1]};
        fits     = shifted >= {1'b0, div_reg};
        rem_next = fits ? MOD_DW'(shifted - {1'b0, div_reg}) : shifted[MOD_DW-1:0];
        rem_s    = $signed({1'b0, rem_reg});
    end

    assign remainder = neg_reg ? -rem_s : rem_s;
    assign done      = done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(MOD_AW - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            mag_reg <= dividend[MOD_AW-1] ? MOD_AW'(-dividend) : dividend;
            neg_reg <= dividend[MOD_AW-1];
            div_reg <= divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            // shift the next dividend bit in, subtract when it fits
            rem_reg <= rem_next;
            mag_reg <= {mag_reg[MOD_AW-2:0], 1'b0};
        end
    end

endmodule

[src/drpu_smul.sv]
// Serial signed multiplier: shift-add over the bits of operand a, one bit a cycle.
// Depends on drpu_pkg.
module drpu_smul
    import drpu_pkg::*;
#(
    parameter int A_W = MUL_AW,
    parameter int B_W = MUL_BW
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic signed [A_W-1:0]    op_a,
    input  logic signed [B_W-1:0]    op_b,
    output logic                     done,
    output logic signed [A_W+B_W-1:0] product
);

    localparam int CNT_W = $clog2(A_W);
    localparam int HW    = B_W + 2;

    logic signed [HW-1:0]  hi_reg;
    logic        [A_W-1:0] lo_reg;
    logic signed [B_W-1:0] b_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic                  busy_reg;
    logic                  done_reg;

    logic signed [HW-1:0]  b_ext;
    logic signed [HW-1:0]  addend;
    logic signed [HW-1:0]  sum;
    logic                  last;

    always_comb
    begin
        b_ext  = {{2{b_reg[B_W-1]}}, b_reg};
        last   = cnt_reg == CNT_W'(A_W - 1);
        // the sign bit of a carries negative weight
        if (!lo_reg[0])
            addend = '0;
        else if (last)
            addend = -b_ext;
        else
            addend = b_ext;
        sum = hi_reg + addend;
    end

    assign product = $signed(A_W'(lo_reg) | ((A_W+B_W)'(hi_reg) << A_W));
    assign done    = done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (last)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            hi_reg <= '0;
            lo_reg <= op_a;
            b_reg  <= op_b;
        end
        else if (busy_reg)
        begin
            hi_reg <= {sum[HW-1], sum[HW-1:1]};
            lo_reg <= {sum[0], lo_reg[A_W-1:1]};
        end
    end

endmodule

[src/drpu_isqrt.sv]
// Serial integer square root: two radicand bits a cycle, one root bit a cycle.
// Depends on drpu_pkg.
module drpu_isqrt
    import drpu_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] radicand,
    output logic        done,
    output logic [31:0] root
);

    logic [63:0] n_reg;
    logic [33:0] rem_reg;
    logic [31:0] root_reg;
    logic [4:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;

    logic [34:0] rem_sh;
    logic [34:0] trial;
    logic        fits;

    always_comb
    begin
        rem_sh = {rem_reg[32:0], n_reg[63:62]};
        trial  = {1'b0, root_reg, 2'b01};
        fits   = rem_sh >= trial;
    end

    assign root = root_reg;
    assign done = done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == 5'd31)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            n_reg    <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            n_reg <= {n_reg[61:0], 2'b00};
            if (fits)
            begin
                rem_reg  <= 34'(rem_sh - trial);
                root_reg <= {root_reg[30:0], 1'b1};
            end
            else
            begin
                rem_reg  <= rem_sh[33:0];
                root_reg <= {root_reg[30:0], 1'b0};
            end
        end
    end

endmodule

[src/drpu_cordic.sv]
// Iterative CORDIC unit, one micro-rotation a cycle, in rotation or vectoring mode.
// Depends on drpu_pkg (atan table, widths, mode type).
module drpu_cordic
    import drpu_pkg::*;
#(
    parameter int STEPS = CORDIC_STEPS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  cordic_mode_t         mode,
    input  logic signed [CW-1:0] x_init,
    input  logic signed [CW-1:0] y_init,
    input  logic signed [ZW-1:0] z_init,
    output logic                 done,
    output logic signed [CW-1:0] x_out,
    output logic signed [CW-1:0] y_out,
    output logic signed [ZW-1:0] z_out
);

    localparam int NSTEP = (STEPS > TABLE_LEN) ? TABLE_LEN : STEPS;
    localparam int IW    = (NSTEP > 1) ? $clog2(NSTEP) : 1;

    logic signed [CW-1:0] x_reg;
    logic signed [CW-1:0] y_reg;
    logic signed [ZW-1:0] z_reg;
    cordic_mode_t         mode_reg;
    logic [IW-1:0]        cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;

    logic                 dir_pos;
    logic signed [CW-1:0] xs;
    logic signed [CW-1:0] ys;
    logic signed [ZW-1:0] at;

    always_comb
    begin
        if (mode_reg == MODE_ROTATE)
            dir_pos = !z_reg[ZW-1];
        else
            dir_pos = y_reg[CW-1] || (y_reg == '0);
        xs = x_reg >>> cnt_reg;
        ys = y_reg >>> cnt_reg;
        at = atan_q30(TIDX_W'(cnt_reg));
    end

    assign x_out = x_reg;
    assign y_out = y_reg;
    assign z_out = z_reg;
    assign done  = done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            mode_reg <= MODE_ROTATE;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                mode_reg <= mode;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == IW'(NSTEP - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg <= x_init;
            y_reg <= y_init;
            z_reg <= z_init;
        end
        else if (busy_reg)
        begin
            if (dir_pos)
            begin
                x_reg <= x_reg - ys;
                y_reg <= y_reg + xs;
                z_reg <= z_reg - at;
            end
            else
            begin
                x_reg <= x_reg + ys;
                y_reg <= y_reg - xs;
                z_reg <= z_reg + at;
            end
        end
    end

endmodule

[src/dead_reckoning_pose_update_top.sv]
// Top level of the dead-reckoning pose update block: sequencer, pose state, output register.
// Depends on drpu_pkg, drpu_smod, drpu_smul, drpu_isqrt and drpu_cordic.
//
// Usage:
//   Input channel (in_valid/in_ready/in_data): one word per robot move, a turn angle
//   (Q4.12 rad, clockwise positive) and a travelled distance (Q16.8 cm).
//   Output channel (out_valid/out_ready/out_data): one word per move with the old and
//   new position, quadrant, range and bearing to the origin, realign angle, home turn.
//   Config channel (cfg_valid/cfg_ready/cfg_data): writes origin_threshold; always ready.
//   Write it only while no move is in flight.
//
// Sequence: a move is processed alone, through serial units in a fixed order:
//   heading remainder, CORDIC rotation, two parallel serial multiplies, two parallel
//   squarings with the realign remainder, square root with CORDIC vectoring alongside,
//   home-turn remainder, then the output step. in_ready rises again as the result
//   moves to the output register, so a new move is taken only once the last one is
//   through. The serial multiplier and root widths set most of the processing time.
//
// Stall: a finished word waits in the output register while out_ready is low; the
// next move is already accepted and processed, and holds in its last step until the
// register frees.
// Reset: heading and position clear to zero, threshold to one, both channels idle.
module dead_reckoning_pose_update_top
    import drpu_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  in_t         in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output out_t        out_data,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data
);

    typedef enum logic [7:0] {
        S_IDLE = 8'b00000001,
        S_HMOD = 8'b00000010,
        S_ROT  = 8'b00000100,
        S_MUL  = 8'b00001000,
        S_SQ   = 8'b00010000,
        S_VEC  = 8'b00100000,
        S_HOME = 8'b01000000,
        S_OUT  = 8'b10000000
    } state_t;

    state_t state_reg, state_next;

    // pose state and configuration
    logic signed [23:0] heading_reg;
    logic signed [31:0] pos_x_reg, pos_y_reg;
    logic [15:0]        thr_reg;

    // per-move working registers
    logic signed [23:0] dist_reg;
    logic signed [31:0] prev_x_reg, prev_y_reg;
    logic               neg_reg;
    logic [2:0]         quad_reg;
    logic signed [15:0] realign_reg;
    logic signed [15:0] bearing_reg;
    logic [31:0]        range_reg;

    out_t               out_reg;
    logic               out_valid_reg;

    // unit hookups
    logic                     mod_start, mod_done;
    logic signed [MOD_AW-1:0] mod_a;
    logic [MOD_DW-1:0]        mod_d;
    logic signed [15:0]       mod_r;

    logic                     cor_start, cor_done;
    cordic_mode_t             cor_mode;
    logic signed [CW-1:0]     cor_x0, cor_y0, cor_x, cor_y;
    logic signed [ZW-1:0]     cor_z0, cor_z;

    logic                     mul_start, mulx_done, muly_done;
    logic signed [MUL_AW-1:0] mulx_a, muly_a;
    logic signed [MUL_BW-1:0] mulx_b, muly_b;
    logic signed [MUL_AW+MUL_BW-1:0] mulx_p, muly_p;

    logic                     sq_start, sq_done;
    logic [63:0]              sq_n;
    logic [31:0]              sq_root;

    logic in_fire;
    assign in_fire   = in_valid && in_ready;
    assign in_ready  = state_reg == S_IDLE;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // heading update with saturation
    logic signed [24:0] h_sum;
    logic signed [23:0] h_sat;
    always_comb
    begin
        h_sum = $signed({heading_reg[23], heading_reg})
              - $signed({{9{in_data.turn_angle[15]}}, in_data.turn_angle});
        if (h_sum[24] != h_sum[23])
            h_sat = h_sum[24] ? 24'sh800000 : 24'sh7FFFFF;
        else
            h_sat = h_sum[23:0];
    end

    // fold the reduced heading into [-pi/2, pi/2]
    logic signed [16:0] r0, r1, r2, r3;
    logic               fold_neg;
    always_comb
    begin
        r0 = 17'(mod_r);
        r1 = r0[16] ? r0 + TWO_PI_TRUE_S : r0;
        r2 = (r1 > PI_TRUE_S) ? r1 - TWO_PI_TRUE_S : r1;
        fold_neg = 1'b0;
        r3 = r2;
        if (r2 > HALF_PI_TRUE_S)
        begin
            r3 = r2 - PI_TRUE_S;
            fold_neg = 1'b1;
        end
        else if (r2 < -HALF_PI_TRUE_S)
        begin
            r3 = r2 + PI_TRUE_S;
            fold_neg = 1'b1;
        end
    end

    // cos and sin out of the rotation, sign restored
    logic signed [CW-1:0] cos_w, sin_w;
    always_comb
    begin
        cos_w = neg_reg ? -cor_x : cor_x;
        sin_w = neg_reg ? -cor_y : cor_y;
    end

    // position step: round half up from Q.38 to Q.8, then saturate
    logic signed [26:0] tx, ty;
    logic signed [26:0] stx, sty;
    logic signed [32:0] px_sum, py_sum;
    logic signed [31:0] px_new, py_new;
    always_comb
    begin
        tx  = mulx_p[55:29];
        ty  = muly_p[55:29];
        stx = (tx + 27'sd1) >>> 1;
        sty = (ty + 27'sd1) >>> 1;
        px_sum = $signed({pos_x_reg[31], pos_x_reg}) + 33'(stx);
        py_sum = $signed({pos_y_reg[31], pos_y_reg}) + 33'(sty);
        if (px_sum[32] != px_sum[31])
            px_new = px_sum[32] ? 32'sh80000000 : 32'sh7FFFFFFF;
        else
            px_new = px_sum[31:0];
        if (py_sum[32] != py_sum[31])
            py_new = py_sum[32] ? 32'sh80000000 : 32'sh7FFFFFFF;
        else
            py_new = py_sum[31:0];
    end

    // magnitudes and quadrant of the new position
    logic [31:0] ax, ay;
    logic [2:0]  quad_w;
    always_comb
    begin
        ax = px_new[31] ? 32'(-px_new) : px_new;
        ay = py_new[31] ? 32'(-py_new) : py_new;
        if (ax < {16'b0, thr_reg} && ay < {16'b0, thr_reg})
            quad_w = 3'd0;
        else if (px_new > 0)
            quad_w = (py_new > 0) ? 3'd4 : 3'd1;
        else
            quad_w = (py_new > 0) ? 3'd3 : 3'd2;
    end

    // bearing from vectoring: round half up from Q.30 to Q.12, negate
    logic signed [ZW-1:0] z_rnd;
    logic signed [15:0]   bearing_w;
    logic                 pos_zero;
    always_comb
    begin
        z_rnd     = cor_z + ZW'(131072);
        pos_zero  = (pos_x_reg == '0) && (pos_y_reg == '0);
        if (quad_reg == 3'd0 || pos_zero)
            bearing_w = '0;
        else
            bearing_w = -$signed(z_rnd[33:18]);
    end

    logic signed [17:0] home_arg;
    assign home_arg = 18'(realign_reg) - PI_CONST_S + 18'(bearing_w);

    // vectoring inputs: the position scaled up by 2^20 (left-half-plane points are pre-rotated in S_SQ)
    logic signed [CW-1:0] vx, vy;
    always_comb
    begin
        vx = CW'(pos_x_reg) <<< 20;
        vy = CW'(pos_y_reg) <<< 20;
    end

    // unit control
    always_comb
    begin
        mod_start = 1'b0;
        mod_a     = h_sat;
        mod_d     = TWO_PI_TRUE;
        cor_start = 1'b0;
        cor_mode  = MODE_ROTATE;
        cor_x0    = GAIN_Q30;
        cor_y0    = '0;
        cor_z0    = {r3[15:0], 18'b0};
        mul_start = 1'b0;
        mulx_a    = MUL_AW'(dist_reg);
        muly_a    = MUL_AW'(dist_reg);
        mulx_b    = MUL_BW'(cos_w);
        muly_b    = MUL_BW'(sin_w);
        sq_start  = 1'b0;
        sq_n      = 64'(mulx_p) + 64'(muly_p);
        state_next = state_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    mod_start  = 1'b1;
                    state_next = S_HMOD;
                end
            end
            S_HMOD:
            begin
                if (mod_done)
                begin
                    cor_start  = 1'b1;
                    state_next = S_ROT;
                end
            end
            S_ROT:
            begin
                if (cor_done)
                begin
                    mul_start  = 1'b1;
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                // square the new magnitudes and reduce the heading for realign
                mulx_a = {1'b0, ax};
                muly_a = {1'b0, ay};
                mulx_b = {2'b0, ax};
                muly_b = {2'b0, ay};
                mod_a  = heading_reg;
                mod_d  = TWO_PI_CONST;
                if (mulx_done)
                begin
                    mul_start  = 1'b1;
                    mod_start  = 1'b1;
                    state_next = S_SQ;
                end
            end
            S_SQ:
            begin
                cor_mode = MODE_VECTOR;
                cor_x0   = vx;
                cor_y0   = vy;
                cor_z0   = '0;
                if (pos_x_reg[31])
                begin
                    if (!pos_y_reg[31])
                    begin
                        cor_x0 = vy;
                        cor_y0 = -vx;
                        cor_z0 = HALF_PI_Q30;
                    end
                    else
                    begin
                        cor_x0 = -vy;
                        cor_y0 = vx;
                        cor_z0 = -HALF_PI_Q30;
                    end
                end
                if (mulx_done)
                begin
                    sq_start   = 1'b1;
                    cor_start  = 1'b1;
                    state_next = S_VEC;
                end
            end
            S_VEC:
            begin
                mod_a = MOD_AW'(home_arg);
                mod_d = TWO_PI_CONST;
                if (sq_done)
                begin
                    mod_start  = 1'b1;
                    state_next = S_HOME;
                end
            end
            S_HOME:
            begin
                if (mod_done)
                    state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!out_valid_reg || out_ready)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            heading_reg   <= '0;
            pos_x_reg     <= '0;
            pos_y_reg     <= '0;
            thr_reg       <= 16'd1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid)
                thr_reg <= cfg_data;
            if (in_fire)
                heading_reg <= h_sat;
            if (state_reg == S_MUL && mulx_done)
            begin
                pos_x_reg <= px_new;
                pos_y_reg <= py_new;
            end
            // drop the word once taken, raise it when a new one lands
            if (state_reg == S_OUT && (!out_valid_reg || out_ready))
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            dist_reg   <= in_data.move_distance;
            prev_x_reg <= pos_x_reg;
            prev_y_reg <= pos_y_reg;
        end
        if (state_reg == S_HMOD && mod_done)
            neg_reg <= fold_neg;
        if (state_reg == S_MUL && mulx_done)
            quad_reg <= quad_w;
        if (state_reg == S_SQ && mulx_done)
            realign_reg <= mod_r;
        if (state_reg == S_VEC && sq_done)
        begin
            bearing_reg <= bearing_w;
            range_reg   <= (quad_reg == 3'd0) ? 32'd0 : sq_root;
        end
        if (state_reg == S_OUT && (!out_valid_reg || out_ready))
        begin
            out_reg.prev_x         <= prev_x_reg;
            out_reg.prev_y         <= prev_y_reg;
            out_reg.new_x          <= pos_x_reg;
            out_reg.new_y          <= pos_y_reg;
            out_reg.quadrant       <= quad_reg;
            out_reg.origin_range   <= range_reg;
            out_reg.origin_bearing <= bearing_reg;
            out_reg.realign_angle  <= realign_reg;
            out_reg.home_turn      <= (quad_reg == 3'd0) ? realign_reg : mod_r;
        end
    end

    drpu_smod u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (mod_start),
        .dividend  (mod_a),
        .divisor   (mod_d),
        .done      (mod_done),
        .remainder (mod_r)
    );

    drpu_cordic #(
        .STEPS (CORDIC_STEPS)
    ) u_cordic (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (cor_start),
        .mode   (cor_mode),
        .x_init (cor_x0),
        .y_init (cor_y0),
        .z_init (cor_z0),
        .done   (cor_done),
        .x_out  (cor_x),
        .y_out  (cor_y),
        .z_out  (cor_z)
    );

    drpu_smul #(
        .A_W (MUL_AW),
        .B_W (MUL_BW)
    ) u_mul_x (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .op_a    (mulx_a),
        .op_b    (mulx_b),
        .done    (mulx_done),
        .product (mulx_p)
    );

    drpu_smul #(
        .A_W (MUL_AW),
        .B_W (MUL_BW)
    ) u_mul_y (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .op_a    (muly_a),
        .op_b    (muly_b),
        .done    (muly_done),
        .product (muly_p)
    );

    drpu_isqrt u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sq_start && muly_done),
        .radicand (sq_n),
        .done     (sq_done),
        .root     (sq_root)
    );

endmodule

[tb/dead_reckoning_pose_update_top_tb.sv]
// Self-checking testbench for the dead-reckoning pose update block.
// Depends on drpu_pkg (word types) and dead_reckoning_pose_update_top.
module dead_reckoning_pose_update_top_tb;
    import drpu_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Fixed-point constants of the pose math (Q.12 angles unless noted)
    localparam int TURN_FULL   = 25736;     // true 2*pi
    localparam int TURN_HALF   = 12868;
    localparam int TURN_QUART  = 6434;
    localparam int WRAP_CONST  = 25723;     // the 6.28 used for realign
    localparam int HALF_CONST  = 12861;     // the 3.14 used for home turn
    localparam longint QUART_Q30 = 64'sd1686629713;
    localparam longint GAIN_Q30L = 64'sd652032874;
    localparam int ROT_STEPS   = (CORDIC_STEPS_DEF > 24) ? 24 : CORDIC_STEPS_DEF;
    localparam int DRAIN_CYCLES = 250;      // longer than one move takes

    typedef enum int {ROW_MOVE, ROW_CFG} row_kind_t;
    typedef enum int {GEN_RANDOM, GEN_SHORT, GEN_STRAIGHT, GEN_HEADING} gen_mode_t;

    typedef struct {
        row_kind_t   kind;
        logic [15:0] turn;
        logic [23:0] span;
        bit          typed;   // expected word typed in below instead of predicted
        out_t        word;
    } stim_row_t;

    logic  clk;
    logic  rst_n;
    logic  in_valid;
    logic  in_ready;
    in_t   in_data;
    logic  out_valid;
    logic  out_ready;
    out_t  out_data;
    logic  cfg_valid;
    logic  cfg_ready;
    logic [15:0] cfg_data;

    // Predictor state: heading, pose and threshold as the block should hold them
    int    heading_acc;
    int    pose_x;
    int    pose_y;
    int    near_thresh;

    out_t  pose_words[$];     // expected output words, oldest first
    int    mismatches;
    bit    quiet;             // no idling on either side
    stim_row_t dir_rows[$];

    longint atan_tab[24] = '{
        843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
        16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143, 131071,
        65535, 32767, 16383, 8191, 4095, 2047, 1023, 511, 255, 127};

    dead_reckoning_pose_update_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Run limit: the slowest legal run is a few ms; allow ten times that
    initial
    begin
        #50ms;
        $display("FAIL");
        $finish;
    end

    function automatic int clamp32(longint v);
        if (v > 64'sd2147483647)
            return 32'h7FFF_FFFF;
        if (v < -64'sd2147483648)
            return 32'h8000_0000;
        return int'(v);
    endfunction

    // Rotate the gain vector by the heading: cos and sin in Q.30
    function automatic void heading_cos_sin(input int hd, output longint c,
                                            output longint s);
        int     r;
        bit     flip;
        longint x;
        longint y;
        longint z;
        longint nx;
        r = hd % TURN_FULL;
        flip = 1'b0;
        x = GAIN_Q30L;
        y = 0;
        if (r < 0)
            r += TURN_FULL;
        if (r > TURN_HALF)
            r -= TURN_FULL;
        if (r > TURN_QUART)
        begin
            r -= TURN_HALF;
            flip = 1'b1;
        end
        else if (r < -TURN_QUART)
        begin
            r += TURN_HALF;
            flip = 1'b1;
        end
        z = longint'(r) * 262144;
        for (int i = 0; i < ROT_STEPS; i++)
        begin
            if (z >= 0)
            begin
                nx = x - (y >>> i);
                y  = y + (x >>> i);
                z -= atan_tab[i];
            end
            else
            begin
                nx = x + (y >>> i);
                y  = y - (x >>> i);
                z += atan_tab[i];
            end
            x = nx;
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endfunction

    // Vector the position onto the x axis: atan2(y, x) in Q.12
    function automatic int pos_angle(int xi, int yi);
        longint x;
        longint y;
        longint z;
        longint t;
        x = longint'(xi) * 1048576;
        y = longint'(yi) * 1048576;
        z = 0;
        if (x < 0)
        begin
            if (y >= 0)
            begin
                t = x; x = y; y = -t; z = QUART_Q30;
            end
            else
            begin
                t = x; x = -y; y = t; z = -QUART_Q30;
            end
        end
        for (int i = 0; i < ROT_STEPS; i++)
        begin
            if (y > 0)
            begin
                t = x + (y >>> i);
                y = y - (x >>> i);
                z += atan_tab[i];
            end
            else
            begin
                t = x - (y >>> i);
                y = y + (x >>> i);
                z -= atan_tab[i];
            end
            x = t;
        end
        return int'((z + 131072) >>> 18);
    endfunction

    function automatic longint unsigned root_floor(longint unsigned n);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n)
            b >>= 2;
        while (b != 0)
        begin
            if (n >= r + b)
            begin
                n -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    // Advance the predicted pose by one move and build the word it should produce
    function automatic out_t advance_pose(in_t mv);
        out_t   w;
        longint hd;
        longint c;
        longint s;
        longint mv_len;
        longint ax;
        longint ay;
        int     bearing;
        int     realign;
        int     home;
        logic [2:0] quad;
        w = '0;
        w.prev_x = pose_x;
        w.prev_y = pose_y;
        hd = longint'(heading_acc) - longint'(mv.turn_angle);
        if (hd > 8388607)
            hd = 8388607;
        if (hd < -8388608)
            hd = -8388608;
        heading_acc = int'(hd);
        heading_cos_sin(heading_acc, c, s);
        mv_len = longint'(mv.move_distance);
        pose_x = clamp32(longint'(pose_x) + ((mv_len * c + 536870912) >>> 30));
        pose_y = clamp32(longint'(pose_y) + ((mv_len * s + 536870912) >>> 30));
        ax = (pose_x < 0) ? -longint'(pose_x) : longint'(pose_x);
        ay = (pose_y < 0) ? -longint'(pose_y) : longint'(pose_y);
        if (ax < near_thresh && ay < near_thresh)
            quad = 3'd0;
        else if (pose_x > 0)
            quad = (pose_y > 0) ? 3'd4 : 3'd1;
        else
            quad = (pose_y > 0) ? 3'd3 : 3'd2;
        bearing = 0;
        if (quad != 3'd0)
        begin
            w.origin_range = 32'(root_floor(longint'(ax * ax) + longint'(ay * ay)));
            if (pose_x != 0 || pose_y != 0)
                bearing = -pos_angle(pose_x, pose_y);
        end
        realign = heading_acc % WRAP_CONST;
        home = (quad != 3'd0) ? (realign - HALF_CONST + bearing) % WRAP_CONST : realign;
        w.new_x          = pose_x;
        w.new_y          = pose_y;
        w.quadrant       = quad;
        w.origin_bearing = 16'(bearing);
        w.realign_angle  = 16'(realign);
        w.home_turn      = 16'(home);
        return w;
    endfunction

    task automatic note_field(string name, longint unsigned e, longint unsigned a);
        if (e != a && mismatches < 10)
            $display("  %s: expected %0h, got %0h", name, e, a);
    endtask

    // Compare each accepted output word with the oldest expectation
    always @(posedge clk)
    begin
        out_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pose_words.size() == 0)
            begin
                if (mismatches < 10)
                    $display("output word with nothing expected at %0t", $realtime);
                mismatches++;
            end
            else
            begin
                want = pose_words.pop_front();
                if (out_data !== want)
                begin
                    if (mismatches < 10)
                        $display("pose word mismatch at %0t", $realtime);
                    note_field("prev_x", 32'(want.prev_x), 32'(out_data.prev_x));
                    note_field("prev_y", 32'(want.prev_y), 32'(out_data.prev_y));
                    note_field("new_x", 32'(want.new_x), 32'(out_data.new_x));
                    note_field("new_y", 32'(want.new_y), 32'(out_data.new_y));
                    note_field("quadrant", want.quadrant, out_data.quadrant);
                    note_field("origin_range", want.origin_range, out_data.origin_range);
                    note_field("origin_bearing", 16'(want.origin_bearing),
                               16'(out_data.origin_bearing));
                    note_field("realign_angle", 16'(want.realign_angle),
                               16'(out_data.realign_angle));
                    note_field("home_turn", 16'(want.home_turn), 16'(out_data.home_turn));
                    mismatches++;
                end
            end
        end
    end

    // Receiver: ready in random runs, dropped for random bursts between them unless quiet is set
    initial
    begin
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            out_ready <= 1'b1;
            repeat ($urandom_range(1, 40)) @(posedge clk);
            if (!quiet && $urandom_range(0, 2) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge clk);
            end
        end
    end

    // Send one move word; the expectation is pushed on the accepting edge
    task automatic send_move(in_t mv, bit typed, out_t typed_word);
        out_t w;
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= mv;
        do
            @(posedge clk);
        while (!in_ready);
        w = advance_pose(mv);
        pose_words.push_back(typed ? typed_word : w);
    endtask

    // Write the threshold only when idle: drain all words, then let the block settle
    task automatic write_threshold(logic [15:0] v);
        in_valid <= 1'b0;
        while (pose_words.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        near_thresh = int'(v);
    endtask

    function automatic stim_row_t move_row(int turn, int len);
        stim_row_t r;
        r.kind  = ROW_MOVE;
        r.turn  = 16'(turn);
        r.span  = 24'(len);
        r.typed = 1'b0;
        r.word  = '0;
        return r;
    endfunction

    function automatic stim_row_t cfg_row(int v);
        stim_row_t r;
        r = move_row(0, 0);
        r.kind = ROW_CFG;
        r.turn = 16'(v);
        return r;
    endfunction

    // Move row with the word typed in: position held at zero, so only angles move
    function automatic stim_row_t still_row(int turn, logic [2:0] quad, int realign,
                                            int home);
        stim_row_t r;
        r = move_row(turn, 0);
        r.typed = 1'b1;
        r.word.quadrant      = quad;
        r.word.realign_angle = 16'(realign);
        r.word.home_turn     = 16'(home);
        return r;
    endfunction

    task automatic build_rows();
        // after reset: at origin, everything zero
        dir_rows.push_back(still_row(0, 3'd0, 0, 0));
        // threshold zero: exact zero position is quadrant 2, bearing zero
        dir_rows.push_back(cfg_row(0));
        dir_rows.push_back(still_row(0, 3'd2, 0, -HALF_CONST));
        // wide threshold: turn extremes, realign wraps at 6.28
        dir_rows.push_back(cfg_row(65535));
        dir_rows.push_back(still_row(-32768, 3'd0, 7045, 7045));
        dir_rows.push_back(still_row(32767, 3'd0, 1, 1));
        dir_rows.push_back(cfg_row(1));
        dir_rows.push_back(move_row(0, 8388607));
        dir_rows.push_back(move_row(0, -8388608));
        dir_rows.push_back(move_row(32767, 8388607));
        dir_rows.push_back(move_row(-32768, -8388608));
        dir_rows.push_back(move_row(TURN_QUART, 256));
        dir_rows.push_back(move_row(TURN_HALF, 100));
        dir_rows.push_back(move_row(-TURN_QUART, 256));
        dir_rows.push_back(move_row(1, 1));
        dir_rows.push_back(move_row(-1, -1));
        dir_rows.push_back(move_row(0, 0));
        dir_rows.push_back(move_row(HALF_CONST, 5000));
        dir_rows.push_back(move_row(-HALF_CONST, -5000));
        dir_rows.push_back(move_row(16'h5555, 24'hAAAAAA));
        dir_rows.push_back(move_row(16'hAAAA, 24'h555555));
    endtask

    function automatic in_t random_move(gen_mode_t mode, bit dir_neg);
        in_t mv;
        mv.turn_angle    = 16'($urandom);
        mv.move_distance = 24'($urandom);
        case (mode)
            GEN_SHORT:
                mv.move_distance = 24'($signed($urandom_range(0, 4000)) - 2000);
            GEN_STRAIGHT:
            begin
                // hold the heading, drive far in one direction to saturate position
                mv.turn_angle = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'sd0;
                mv.move_distance = dir_neg ? -24'($urandom_range(4000000, 8388608))
                                           : 24'($urandom_range(4000000, 8388607));
            end
            GEN_HEADING:
                // push the heading to its saturation limit
                mv.turn_angle = dir_neg ? -16'($urandom_range(20000, 32768))
                                        : 16'($urandom_range(20000, 32767));
            default: ;
        endcase
        return mv;
    endfunction

    initial
    begin
        gen_mode_t   modes[7]  = '{GEN_SHORT, GEN_RANDOM, GEN_HEADING, GEN_STRAIGHT,
                                   GEN_RANDOM, GEN_STRAIGHT, GEN_RANDOM};
        int          counts[7] = '{250, 200, 300, 300, 200, 300, 200};
        int          thr;
        bit          dir_neg;
        in_t         mv;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        quiet     = 1'b0;
        mismatches  = 0;
        heading_acc = 0;
        pose_x      = 0;
        pose_y      = 0;
        near_thresh = 1;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part: walk the table
        build_rows();
        foreach (dir_rows[i])
        begin
            if (dir_rows[i].kind == ROW_CFG)
                write_threshold(dir_rows[i].turn);
            else
            begin
                mv.turn_angle    = dir_rows[i].turn;
                mv.move_distance = dir_rows[i].span;
                send_move(mv, dir_rows[i].typed, dir_rows[i].word);
            end
        end

        // random part: one threshold per phase; the drain before each write is the pause
        for (int p = 0; p < 7; p++)
        begin
            case (p)
                0: thr = 65535;
                1: thr = 1;
                4: thr = 0;
                default: thr = $urandom_range(0, 65535);
            endcase
            write_threshold(16'(thr));
            quiet = (p == 6);
            dir_neg = $urandom_range(0, 1);
            for (int n = 0; n < counts[p]; n++)
                send_move(random_move(modes[p], dir_neg), 1'b0, '0);
        end
        in_valid <= 1'b0;

        while (pose_words.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
